@@ rtl/tcg_pkg.sv @@
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared types and codes for the text cell grid: item modes, controller
// states, datapath commands and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package tcg_pkg;

    localparam int CELL_DATA_W = 16;  // char byte over attribute byte

    typedef enum logic [2:0] {
        MODE_CLEAR = 3'd0,
        MODE_WRITE = 3'd1,
        MODE_FILL  = 3'd2,
        MODE_MARK  = 3'd3,
        MODE_TAKE  = 3'd4,
        MODE_READ  = 3'd5
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WR_CMP,
        ST_FILL,
        ST_ROW_WB,
        ST_MARK,
        ST_SCAN,
        ST_RUN_WALK,
        ST_RUN_WB,
        ST_RD_DATA,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR_STEP,
        DP_CELL_UPD,
        DP_FILL_STEP,
        DP_ROW_WB,
        DP_MARK,
        DP_SCAN_STEP,
        DP_RUN_STEP,
        DP_RUN_WB,
        DP_READ_CAPTURE,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   set_ok;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] in_mode;
        logic       in_row_ok;
        logic       in_cell_ok;
        logic       sweep_last;
        logic       col_last;
        logic       row_nz;
        logic       scan_last;
        logic       run_done;
        logic       out_busy;
    } dp_status_t;

endpackage

@@ rtl/tcg_if.sv @@
// ----------------------------------------------------------------------------
// tcg_if
// Valid/ready channels of the text cell grid: the item channel and the
// result channel.
// ----------------------------------------------------------------------------
interface tcg_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] row_index;
    logic [7:0] col_index;
    logic [7:0] char_code;
    logic [7:0] attr_byte;

    modport source (output valid, mode, row_index, col_index, char_code, attr_byte,
                    input ready);
    modport sink   (input valid, mode, row_index, col_index, char_code, attr_byte,
                    output ready);
endinterface

interface tcg_result_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] run_row;
    logic [5:0] run_start;
    logic [6:0] run_length;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;

    modport source (output valid, ok, run_row, run_start, run_length, cell_char,
                    cell_attr, input ready);
    modport sink   (input valid, ok, run_row, run_start, run_length, cell_char,
                    cell_attr, output ready);
endinterface

@@ rtl/text_cell_grid_dirty_runs_top.sv @@
// ----------------------------------------------------------------------------
// text_cell_grid_dirty_runs_top
// Text cell grid of char/attribute bytes with per-row dirty bitmaps and
// first-dirty-run extraction.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel (valid/ready): one transaction per command; mode selects
//    clear, write cell, fill row, mark all dirty, take run or read cell.
//  - result channel (valid/ready): exactly one transaction per item, in order.
//  - One item is in work at a time. Work from acceptance to result valid:
//      write, read, mark                 : compare, capture or mark state
//      bad index/mode                    : straight to the result
//      fill row                          : column walk, then row write-back
//      clear                             : sweep of all cells (one cell per cycle)
//      take run : row scan of up to ROWS rows, column walk of up to COLS, write-back
//    Cell store has one write and one read port with registered read; each
//    write is a read-compare-write, fill and clear walk that port.
//  - A finished result sits in an output register; the next item is accepted
//    while it waits. When the receiver stalls, the following result waits in
//    the sequencer until the output register frees up.
//  - Reset clears the dirty bitmaps (via row override flags) and the output
//    valid. Cell contents are undefined until the first clear item.
// ----------------------------------------------------------------------------
module text_cell_grid_dirty_runs_top #(
    parameter int ROWS = 16,
    parameter int COLS = 32
) (
    input logic          clk,
    input logic          rst_n,
    tcg_item_if.sink     item,
    tcg_result_if.source result
);
    import tcg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: owns item ready, steps the datapath
    tcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // stores, walk counters and output register
    tcg_dpath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .mode       (item.mode),
        .row_index  (item.row_index),
        .col_index  (item.col_index),
        .char_code  (item.char_code),
        .attr_byte  (item.attr_byte),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .ok         (result.ok),
        .run_row    (result.run_row),
        .run_start  (result.run_start),
        .run_length (result.run_length),
        .cell_char  (result.cell_char),
        .cell_attr  (result.cell_attr)
    );

endmodule

@@ rtl/tcg_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcg_ctrl
// Sequencer: decodes the accepted item and steps the datapath through the
// clear sweep, read-compare-write, row fill, row scan and run walk.
// ----------------------------------------------------------------------------
module tcg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcg_pkg::dp_status_t status,
    output tcg_pkg::dp_cmd_t    cmd
);
    import tcg_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (status.in_mode)
                        MODE_CLEAR: state_next = ST_CLEAR;
                        MODE_WRITE: state_next = status.in_cell_ok ? ST_WR_CMP : ST_DONE;
                        MODE_FILL:  state_next = status.in_row_ok ? ST_FILL : ST_DONE;
                        MODE_MARK:  state_next = ST_MARK;
                        MODE_TAKE:  state_next = ST_SCAN;
                        MODE_READ:  state_next = status.in_cell_ok ? ST_RD_DATA : ST_DONE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WR_CMP:   state_next = ST_DONE;
            ST_FILL:
            begin
                if (status.col_last)
                begin
                    state_next = ST_ROW_WB;
                end
            end
            ST_ROW_WB:   state_next = ST_DONE;
            ST_MARK:     state_next = ST_DONE;
            ST_SCAN:
            begin
                if (status.row_nz)
                begin
                    state_next = ST_RUN_WALK;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN_WALK:
            begin
                if (status.run_done)
                begin
                    state_next = ST_RUN_WB;
                end
            end
            ST_RUN_WB:   state_next = ST_DONE;
            ST_RD_DATA:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.op     = DP_NOP;
        cmd.set_ok = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? DP_LOAD : DP_NOP;
            end
            ST_CLEAR:
            begin
                cmd.op     = DP_CLEAR_STEP;
                cmd.set_ok = 1'b1;
            end
            ST_WR_CMP:
            begin
                cmd.op     = DP_CELL_UPD;
                cmd.set_ok = 1'b1;
            end
            ST_FILL:     cmd.op = DP_FILL_STEP;
            ST_ROW_WB:
            begin
                cmd.op     = DP_ROW_WB;
                cmd.set_ok = 1'b1;
            end
            ST_MARK:
            begin
                cmd.op     = DP_MARK;
                cmd.set_ok = 1'b1;
            end
            ST_SCAN:     cmd.op = DP_SCAN_STEP;
            ST_RUN_WALK: cmd.op = DP_RUN_STEP;
            ST_RUN_WB:
            begin
                cmd.op     = DP_RUN_WB;
                cmd.set_ok = 1'b1;
            end
            ST_RD_DATA:
            begin
                cmd.op     = DP_READ_CAPTURE;
                cmd.set_ok = 1'b1;
            end
            ST_DONE:     cmd.op = status.out_busy ? DP_NOP : DP_EMIT;
            default:     cmd.op = DP_NOP;
        endcase
    end

endmodule

@@ rtl/tcg_dpath.sv @@
// ----------------------------------------------------------------------------
// tcg_dpath
// Cell store, per-row dirty store with override flags, walk counters,
// result register and output register.
// ----------------------------------------------------------------------------
module tcg_dpath #(
    parameter int ROWS = 16,
    parameter int COLS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcg_pkg::dp_cmd_t    cmd,
    output tcg_pkg::dp_status_t status,
    // item payload
    input  logic [2:0]          mode,
    input  logic [7:0]          row_index,
    input  logic [7:0]          col_index,
    input  logic [7:0]          char_code,
    input  logic [7:0]          attr_byte,
    // result side
    input  logic                out_ready,
    output logic                out_valid,
    output logic                ok,
    output logic [7:0]          run_row,
    output logic [5:0]          run_start,
    output logic [6:0]          run_length,
    output logic [7:0]          cell_char,
    output logic [7:0]          cell_attr
);
    import tcg_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [7:0] ROW_LIMIT = 8'(ROWS);
    localparam logic [7:0] COL_LIMIT = 8'(COLS);

    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        logic [31:0] full;
        full = 32'(r) * 32'(COLS) + 32'(c);
        return full[CELL_W-1:0];
    endfunction

    // storage
    logic [CELL_DATA_W-1:0] cell_mem [CELLS];
    logic [COLS-1:0]        dirty_mem [ROWS];
    logic [CELL_DATA_W-1:0] cell_rdata_reg;
    logic [COLS-1:0]        dirty_rdata_reg;

    // row override: an overridden row reads as all ovr_val_reg
    logic [ROWS-1:0] ovr_reg;
    logic            ovr_val_reg;
    logic [ROWS-1:0] nz_reg;

    // item and walk registers
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [7:0]        ch_reg;
    logic [7:0]        at_reg;
    logic [CELL_W-1:0] cnt_reg;
    logic [COL_W-1:0]  colc_reg;
    logic [ROW_W-1:0]  scan_reg;
    logic [COLS-1:0]   word_reg;
    logic              in_run_reg;
    logic [5:0]        start_reg;
    logic [6:0]        len_reg;

    // result register
    logic       res_ok_reg;
    logic [7:0] res_row_reg;
    logic [5:0] res_start_reg;
    logic [6:0] res_len_reg;
    logic [7:0] res_char_reg;
    logic [7:0] res_attr_reg;

    // output register
    logic       out_valid_reg;
    logic       out_ok_reg;
    logic [7:0] out_row_reg;
    logic [5:0] out_start_reg;
    logic [6:0] out_len_reg;
    logic [7:0] out_char_reg;
    logic [7:0] out_attr_reg;

    logic [ROW_W-1:0]       in_row_idx;
    logic [COL_W-1:0]       in_col_idx;
    logic [CELL_W-1:0]      cell_raddr;
    logic                   cell_we;
    logic [CELL_W-1:0]      cell_waddr;
    logic [CELL_DATA_W-1:0] cell_wdata;
    logic [ROW_W-1:0]       dirty_raddr;
    logic                   dw_en;
    logic [ROW_W-1:0]       dw_row;
    logic [COLS-1:0]        dw_data;
    logic [ROW_W-1:0]       eff_row;
    logic [COLS-1:0]        eff_dirty;
    logic [COLS-1:0]        base_word;
    logic [COLS-1:0]        col_bit;
    logic                   cur_bit;
    logic                   changed;
    logic [COLS-1:0]        word_next;

    assign in_row_idx = row_index[ROW_W-1:0];
    assign in_col_idx = col_index[COL_W-1:0];

    assign changed   = (cell_rdata_reg != {ch_reg, at_reg});
    assign eff_row   = (cmd.op == DP_RUN_STEP) ? scan_reg : row_reg;
    assign eff_dirty = ovr_reg[eff_row] ? {COLS{ovr_val_reg}} : dirty_rdata_reg;
    // first walk step takes the row fresh from the store
    assign base_word = (colc_reg == '0) ? eff_dirty : word_reg;
    assign col_bit   = COLS'(1) << colc_reg;
    assign cur_bit   = base_word[colc_reg];

    always_comb
    begin
        word_next = base_word;
        case (cmd.op)
            DP_FILL_STEP: word_next = changed ? (base_word | col_bit) : base_word;
            DP_RUN_STEP:  word_next = cur_bit ? (base_word & ~col_bit) : base_word;
            default:      word_next = base_word;
        endcase
    end

    // read addresses
    always_comb
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                cell_raddr  = cell_addr(in_row_idx,
                                        (mode == MODE_FILL) ? '0 : in_col_idx);
                dirty_raddr = in_row_idx;
            end
            DP_FILL_STEP:
            begin
                cell_raddr  = cell_addr(row_reg, COL_W'(colc_reg + 1'b1));
                dirty_raddr = row_reg;
            end
            DP_SCAN_STEP:
            begin
                cell_raddr  = cell_addr(row_reg, col_reg);
                dirty_raddr = scan_reg;
            end
            default:
            begin
                cell_raddr  = cell_addr(row_reg, col_reg);
                dirty_raddr = row_reg;
            end
        endcase
    end

    // write ports
    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = cell_addr(row_reg, col_reg);
        cell_wdata = {ch_reg, at_reg};
        dw_en      = 1'b0;
        dw_row     = row_reg;
        dw_data    = word_reg;
        case (cmd.op)
            DP_CLEAR_STEP:
            begin
                cell_we    = 1'b1;
                cell_waddr = cnt_reg;
            end
            DP_CELL_UPD:
            begin
                cell_we = changed;
                dw_en   = changed;
                dw_data = eff_dirty | (COLS'(1) << col_reg);
            end
            DP_FILL_STEP:
            begin
                cell_we    = changed;
                cell_waddr = cell_addr(row_reg, colc_reg);
            end
            DP_ROW_WB:    dw_en = 1'b1;
            DP_RUN_WB:
            begin
                dw_en  = 1'b1;
                dw_row = scan_reg;
            end
            default:      dw_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rdata_reg <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dw_en)
        begin
            dirty_mem[dw_row] <= dw_data;
        end
        dirty_rdata_reg <= dirty_mem[dirty_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovr_reg     <= '1;
            ovr_val_reg <= 1'b0;
            nz_reg      <= '0;
        end
        else
        begin
            case (cmd.op)
                DP_CLEAR_STEP:
                begin
                    ovr_reg     <= '1;
                    ovr_val_reg <= 1'b0;
                    nz_reg      <= '0;
                end
                DP_MARK:
                begin
                    ovr_reg     <= '1;
                    ovr_val_reg <= 1'b1;
                    nz_reg      <= '1;
                end
                default:
                begin
                    if (dw_en)
                    begin
                        ovr_reg[dw_row] <= 1'b0;
                        nz_reg[dw_row]  <= |dw_data;
                    end
                end
            endcase
        end
    end

    // item, walk and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                row_reg       <= in_row_idx;
                col_reg       <= in_col_idx;
                ch_reg        <= char_code;
                at_reg        <= attr_byte;
                cnt_reg       <= '0;
                colc_reg      <= '0;
                scan_reg      <= '0;
                res_row_reg   <= '0;
                res_start_reg <= '0;
                res_len_reg   <= '0;
                res_char_reg  <= '0;
                res_attr_reg  <= '0;
            end
            DP_CLEAR_STEP: cnt_reg <= cnt_reg + 1'b1;
            DP_FILL_STEP:
            begin
                word_reg <= word_next;
                colc_reg <= colc_reg + 1'b1;
            end
            DP_SCAN_STEP:
            begin
                colc_reg   <= '0;
                in_run_reg <= 1'b0;
                len_reg    <= '0;
                start_reg  <= '0;
                if (!nz_reg[scan_reg])
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            DP_RUN_STEP:
            begin
                word_reg <= word_next;
                colc_reg <= colc_reg + 1'b1;
                if (cur_bit)
                begin
                    if (!in_run_reg)
                    begin
                        start_reg  <= 6'(colc_reg);
                        len_reg    <= 7'd1;
                        in_run_reg <= 1'b1;
                    end
                    else
                    begin
                        len_reg <= len_reg + 7'd1;
                    end
                end
            end
            DP_RUN_WB:
            begin
                res_row_reg   <= 8'(scan_reg);
                res_start_reg <= start_reg;
                res_len_reg   <= len_reg;
            end
            DP_READ_CAPTURE:
            begin
                res_char_reg <= cell_rdata_reg[15:8];
                res_attr_reg <= cell_rdata_reg[7:0];
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ok_reg <= 1'b0;
        end
        else if (cmd.op == DP_LOAD)
        begin
            res_ok_reg <= 1'b0;
        end
        else if (cmd.set_ok)
        begin
            res_ok_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == DP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_EMIT)
        begin
            out_ok_reg    <= res_ok_reg;
            out_row_reg   <= res_row_reg;
            out_start_reg <= res_start_reg;
            out_len_reg   <= res_len_reg;
            out_char_reg  <= res_char_reg;
            out_attr_reg  <= res_attr_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = out_ok_reg;
    assign run_row    = out_row_reg;
    assign run_start  = out_start_reg;
    assign run_length = out_len_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;

    assign status.in_mode    = mode;
    assign status.in_row_ok  = (row_index < ROW_LIMIT);
    assign status.in_cell_ok = (row_index < ROW_LIMIT) && (col_index < COL_LIMIT);
    assign status.sweep_last = (cnt_reg == CELL_W'(CELLS - 1));
    assign status.col_last   = (colc_reg == COL_W'(COLS - 1));
    assign status.row_nz     = nz_reg[scan_reg];
    assign status.scan_last  = (scan_reg == ROW_W'(ROWS - 1));
    assign status.run_done   = (in_run_reg && !cur_bit) || (colc_reg == COL_W'(COLS - 1));
    assign status.out_busy   = out_valid_reg && !out_ready;

endmodule

@@ rtl/tcg_checker.sv @@
// ----------------------------------------------------------------------------
// tcg_checker
// Port-level checks for the text cell grid, bound to the top level.
// ----------------------------------------------------------------------------
module tcg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       ok,
    input logic [7:0] run_row,
    input logic [5:0] run_start,
    input logic [6:0] run_length,
    input logic [7:0] cell_char,
    input logic [7:0] cell_attr
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(run_row)
            && $stable(run_start) && $stable(run_length) && $stable(cell_char)
            && $stable(cell_attr))
        else $error("result changed while stalled");

    // one item at a time: ready drops after a transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous still in work");

    // a result only appears after work, never straight from idle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without an item in work");

    // failed items carry all-zero fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> run_row == 8'd0 && run_start == 6'd0
            && run_length == 7'd0 && cell_char == 8'd0 && cell_attr == 8'd0)
        else $error("nonzero fields on failed item");

endmodule

bind text_cell_grid_dirty_runs_top tcg_checker u_tcg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .ok         (result.ok),
    .run_row    (result.run_row),
    .run_start  (result.run_start),
    .run_length (result.run_length),
    .cell_char  (result.cell_char),
    .cell_attr  (result.cell_attr)
);

@@ bench/tb_text_cell_grid_dirty_runs_top.sv @@
// ----------------------------------------------------------------------------
// tb_text_cell_grid_dirty_runs_top
// Self-checking bench for the text cell grid: a cell and dirty-map model runs
// beside the block, predicts one result per accepted item and compares every
// result field; directed edge cases first, then random traffic with idling.
// ----------------------------------------------------------------------------
module tb_text_cell_grid_dirty_runs_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcg_pkg::*;

    localparam int ROWS = 16;
    localparam int COLS = 32;
    localparam int CELLS = ROWS * COLS;

    // Mode codes the block must ignore.
    localparam logic [2:0] MODE_BAD_LO = 3'd6;
    localparam logic [2:0] MODE_BAD_HI = 3'd7;

    // Idle percentage per side, stall limit and drain time at the end.
    localparam int IDLE_PCT     = 31;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = CELLS + 64;

    typedef struct packed {
        logic       ok;
        logic [7:0] run_row;
        logic [5:0] run_start;
        logic [6:0] run_length;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } grid_answer_t;

    logic clk;
    logic rst_n;

    tcg_item_if   item_ch ();
    tcg_result_if result_ch ();

    text_cell_grid_dirty_runs_top #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Model of the grid contents and the per-row dirty bitmaps.
    logic [7:0]      char_grid [CELLS];
    logic [7:0]      attr_grid [CELLS];
    logic [COLS-1:0] dirty_map [ROWS];

    // Answers owed by the block, oldest first.
    grid_answer_t grid_answers_due [$];

    int  failures = 0;
    int  quiet_cycles = 0;
    bit  sender_steady;   // 1: item side never idles
    bit  receiver_steady; // 1: result side never stalls

    // ------------------------------------------------------------------------
    // Clock: 10 ns period.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------------

    // Cell store with change detect: dirty bit only when content differs.
    function automatic void store_cell(int row, int col, logic [7:0] ch, logic [7:0] at);
        int idx;
        idx = row * COLS + col;
        if (char_grid[idx] != ch || attr_grid[idx] != at)
        begin
            char_grid[idx]      = ch;
            attr_grid[idx]      = at;
            dirty_map[row][col] = 1'b1;
        end
    endfunction

    // Applies one item to the model and returns the answer it owes.
    function automatic grid_answer_t grid_step(logic [2:0] mode, logic [7:0] row,
                                               logic [7:0] col, logic [7:0] ch,
                                               logic [7:0] at);
        grid_answer_t ans;
        bit           row_ok;
        bit           cell_ok;
        bit           found;
        int           start;
        int           stop;
        ans     = '0;
        row_ok  = row < ROWS;
        cell_ok = row_ok && col < COLS;
        found   = 1'b0;
        case (mode)
            MODE_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    char_grid[i] = ch;
                    attr_grid[i] = at;
                end
                for (int r = 0; r < ROWS; r++)
                    dirty_map[r] = '0;
                ans.ok = 1'b1;
            end
            MODE_WRITE:
            begin
                if (cell_ok)
                begin
                    store_cell(row, col, ch, at);
                    ans.ok = 1'b1;
                end
            end
            MODE_FILL:
            begin
                if (row_ok)
                begin
                    for (int c = 0; c < COLS; c++)
                        store_cell(row, c, ch, at);
                    ans.ok = 1'b1;
                end
            end
            MODE_MARK:
            begin
                for (int r = 0; r < ROWS; r++)
                    dirty_map[r] = '1;
                ans.ok = 1'b1;
            end
            MODE_TAKE:
            begin
                // Lowest dirty row, lowest contiguous run in it.
                for (int r = 0; r < ROWS && !found; r++)
                begin
                    if (dirty_map[r] != '0)
                    begin
                        start = 0;
                        while (!dirty_map[r][start])
                            start++;
                        stop = start;
                        while (stop < COLS && dirty_map[r][stop])
                            stop++;
                        for (int c = start; c < stop; c++)
                            dirty_map[r][c] = 1'b0;
                        ans.ok         = 1'b1;
                        ans.run_row    = 8'(r);
                        ans.run_start  = 6'(start);
                        ans.run_length = 7'(stop - start);
                        found          = 1'b1;
                    end
                end
            end
            MODE_READ:
            begin
                if (cell_ok)
                begin
                    ans.cell_char = char_grid[row * COLS + col];
                    ans.cell_attr = attr_grid[row * COLS + col];
                    ans.ok        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Item side: one transaction per call, optional random idle beforehand.
    // valid stays high between back-to-back items so it is never dropped and
    // raised within one time step.
    // ------------------------------------------------------------------------
    task automatic send_item(logic [2:0] mode, logic [7:0] row, logic [7:0] col,
                             logic [7:0] ch, logic [7:0] at);
        while (!sender_steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= mode;
        item_ch.row_index <= row;
        item_ch.col_index <= col;
        item_ch.char_code <= ch;
        item_ch.attr_byte <= at;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        // Accepted at this edge: update the model now, ahead of the
        // result.
        grid_answers_due.push_back(grid_step(mode, row, col, ch, at));
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall on ready, compare on each transaction.
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected, actual);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        grid_answer_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (grid_answers_due.size() == 0)
            begin
                $display("%0t ns: result with none expected, ok %0d row %0d start %0d",
                         $time, result_ch.ok, result_ch.run_row, result_ch.run_start);
                failures++;
            end
            else
            begin
                want = grid_answers_due.pop_front();
                check_field("ok", want.ok, result_ch.ok);
                check_field("run_row", want.run_row, result_ch.run_row);
                check_field("run_start", want.run_start, result_ch.run_start);
                check_field("run_length", want.run_length, result_ch.run_length);
                check_field("cell_char", want.cell_char, result_ch.cell_char);
                check_field("cell_attr", want.cell_attr, result_ch.cell_attr);
            end
        end
        result_ch.ready <= rst_n && (receiver_steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no transaction on either channel. The slowest
    // item (a clear, one cell per cycle) is well inside the limit.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("text_cell_grid_dirty_runs_top verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Before any clear: dirty-map modes and ignored codes, then the first clear.
    // Cell store is undefined until then, so nothing before it may write or read a cell.
    task automatic test_fresh_grid();
        send_item(MODE_TAKE, 8'd0, 8'd0, 8'd0, 8'd0);        // nothing dirty
        send_item(MODE_BAD_LO, 8'd3, 8'd4, 8'h12, 8'h34);
        send_item(MODE_BAD_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(MODE_MARK, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(MODE_TAKE, 8'd0, 8'd0, 8'd0, 8'd0);        // full row 0
        send_item(MODE_CLEAR, 8'd0, 8'd0, 8'hFF, 8'h00);     // drops marks too
    endtask

    // Corners, no-change writes, bad indices and runs of known shape.
    task automatic test_cell_edges();
        send_item(MODE_WRITE, 8'd0, 8'd0, 8'h41, 8'h07);
        send_item(MODE_WRITE, 8'd0, 8'd0, 8'h41, 8'h07);     // same content
        send_item(MODE_WRITE, 8'd0, 8'd1, 8'hFF, 8'h80);     // attr only changes
        send_item(MODE_WRITE, 8'(ROWS - 1), 8'(COLS - 1), 8'h5A, 8'hA5);
        send_item(MODE_WRITE, 8'd255, 8'd0, 8'h11, 8'h22);  // row out of range
        send_item(MODE_WRITE, 8'd0, 8'd255, 8'h11, 8'h22);  // column out of range
        send_item(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(MODE_READ, 8'(ROWS - 1), 8'(COLS - 1), 8'd0, 8'd0);
        send_item(MODE_READ, 8'(ROWS), 8'd0, 8'd0, 8'd0);
        send_item(MODE_READ, 8'd0, 8'(COLS), 8'd0, 8'd0);
        send_item(MODE_FILL, 8'(ROWS - 1), 8'd200, 8'h20, 8'h07); // column ignored
        send_item(MODE_FILL, 8'd200, 8'd0, 8'h20, 8'h07);     // bad row
        send_item(MODE_TAKE, 8'd0, 8'd0, 8'd0, 8'd0);         // row 0, cols 0..1
        send_item(MODE_TAKE, 8'd0, 8'd0, 8'd0, 8'd0);         // whole last row
        send_item(MODE_TAKE, 8'd0, 8'd0, 8'd0, 8'd0);         // none left
    endtask

    // Mixed random traffic. Rows cluster on a few so writes build runs, a
    // small byte palette makes same-content writes common, and clears stay
    // rare since each walks the whole grid.
    task automatic random_grid_traffic(int count);
        int         pick;
        logic [2:0] mode;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] ch;
        logic [7:0] at;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            row  = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, ROWS - 1))
                                               : 8'($urandom_range(0, 3));
            col  = 8'($urandom_range(0, COLS - 1));
            if ($urandom_range(0, 1) == 0)
            begin
                ch = 8'($urandom_range(0, 255));
                at = 8'($urandom_range(0, 255));
            end
            else
            begin
                ch = 8'($urandom_range(0, 2));
                at = 8'($urandom_range(0, 1));
            end
            if (pick < 34)
                mode = MODE_WRITE;
            else if (pick < 42)
            begin
                // Rewrite of the current content: must not mark dirty.
                mode = MODE_WRITE;
                ch   = char_grid[row * COLS + col];
                at   = attr_grid[row * COLS + col];
            end
            else if (pick < 47)
            begin
                case ($urandom_range(0, 2))
                    0: mode = MODE_WRITE;
                    1: mode = MODE_READ;
                    default: mode = MODE_FILL;
                endcase
                if ($urandom_range(0, 1) == 0)
                    row = 8'($urandom_range(ROWS, 255));
                else
                    col = 8'($urandom_range(COLS, 255));
            end
            else if (pick < 52)
            begin
                mode = MODE_FILL;
                col  = 8'($urandom_range(0, 255));
            end
            else if (pick < 54)
                mode = MODE_MARK;
            else if (pick < 76)
                mode = MODE_TAKE;
            else if (pick < 92)
                mode = MODE_READ;
            else if (pick < 94)
                mode = ($urandom_range(0, 1) == 0) ? MODE_BAD_LO : MODE_BAD_HI;
            else if (pick < 95)
                mode = MODE_CLEAR;
            else
                mode = MODE_TAKE;
            send_item(mode, row, col, ch, at);
        end
    endtask

    // Both sides at full rate for a while.
    task automatic test_steady_stream(int count);
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        random_grid_traffic(count);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sender_steady     = 1'b0;
        receiver_steady   = 1'b0;
        for (int r = 0; r < ROWS; r++)
            dirty_map[r] = '0;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.mode      = MODE_TAKE;
        item_ch.row_index = '0;
        item_ch.col_index = '0;
        item_ch.char_code = '0;
        item_ch.attr_byte = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fresh_grid();
        test_cell_edges();
        random_grid_traffic(600);
        test_steady_stream(200);
        random_grid_traffic(630);

        item_ch.valid <= 1'b0;
        while (grid_answers_due.size() != 0)
            @(posedge clk);
        // Catch any stray result after the last one owed.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("text_cell_grid_dirty_runs_top verification clean");
        else
            $display("text_cell_grid_dirty_runs_top verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tcg_pkg.sv
rtl/tcg_if.sv
rtl/tcg_ctrl.sv
rtl/tcg_dpath.sv
rtl/text_cell_grid_dirty_runs_top.sv
rtl/tcg_checker.sv
bench/tb_text_cell_grid_dirty_runs_top.sv
